/* rtl/tq_pkg.sv */
package tq_pkg;

    localparam int CMD_W    = 2;
    localparam int SLOT_W   = 5;
    localparam int TICK_W   = 32;
    localparam int GRAN_W   = 31;
    localparam int PER_W    = 32;
    localparam int PADDR_W  = 3;
    localparam int IN_W     = 72;
    localparam int OUT_W    = 40;

    localparam logic [PADDR_W-1:0] ADDR_GRAN = 3'd0;

    typedef enum logic [CMD_W-1:0] {
        CMD_ARM      = 2'd0,
        CMD_ARM_LAST = 2'd1,
        CMD_CANCEL   = 2'd2,
        CMD_DISPATCH = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_DIV,
        ST_EMIT
    } state_t;

    localparam logic KIND_FIRED = 1'b0;
    localparam logic KIND_SLEEP = 1'b1;

    localparam logic [PER_W-1:0] PER_NONE = '1;
    localparam logic [PER_W-1:0] PER_MAX  = {1'b0, {(PER_W-1){1'b1}}};

endpackage

/* rtl/timed_event_queue.sv */
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  tdata: command, slot, wakeup_tick, now_tick
// m_        out  m_tvalid/m_tready  tdata: fired_slot, sleep_periods; tuser kind; tlast
// apb       in   psel/penable       register 0 tick granularity (pready tied high)
//
// Arm and cancel are taken in idle; an arm writes the wakeup RAM, a cancel
// only clears the armed bit. Dispatch: each result costs one scan of the
// wakeup RAM (one read per slot, then one decide step and one emit step); a
// final report with a wakeup left also runs the bit-serial divider.
// Reset clears armed bits, last dispatch tick and granularity (to 1).
// Output is a register; a stalled m_tready holds the dispatch in its emit step.
module timed_event_queue
    import tq_pkg::*;
    #(
    parameter int SLOTS = 32
    )
    (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [IN_W-1:0]    s_tdata,   // command, slot, wakeup_tick, now_tick
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata,   // fired_slot, sleep_periods
    output logic               m_tuser,   // kind
    output logic               m_tlast,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
    );

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int SCAN_W = $clog2(SLOTS + 1);

    // input unpacking
    logic [CMD_W-1:0]  in_cmd;
    logic [SLOT_W-1:0] in_slot;
    logic [TICK_W-1:0] in_wake;
    logic [TICK_W-1:0] in_now;
    logic [6:0]        slot_ext;
    logic              slot_ok;
    logic [IDX_W-1:0]  slot_idx;

    assign in_cmd   = s_tdata[1:0];
    assign in_slot  = s_tdata[6:2];
    assign in_wake  = s_tdata[38:7];
    assign in_now   = s_tdata[70:39];
    assign slot_ext = {2'b00, in_slot};
    assign slot_ok  = slot_ext < 7'(SLOTS);
    assign slot_idx = slot_ext[IDX_W-1:0];

    // configuration
    logic [GRAN_W-1:0] gran_reg;
    logic [GRAN_W-1:0] gran;
    logic [GRAN_W-1:0] half;

    assign pready = 1'b1;
    assign gran   = (gran_reg == '0) ? GRAN_W'(1) : gran_reg;
    assign half   = gran >> 1;
    assign prdata = (paddr == ADDR_GRAN) ? {1'b0, gran_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gran_reg <= GRAN_W'(1);
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_GRAN)
        begin
            gran_reg <= pwdata[GRAN_W-1:0];
        end
    end

    // state
    state_t             state_reg, state_next;
    logic [SLOTS-1:0]   armed_reg, armed_next;
    logic [TICK_W-1:0]  last_tick_reg, last_tick_next;
    logic [TICK_W-1:0]  now_reg, now_next;
    logic [SCAN_W-1:0]  scan_reg, scan_next;
    logic               ev_vld_reg, ev_vld_next;
    logic [IDX_W-1:0]   ev_idx_reg, ev_idx_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [TICK_W-1:0]  best_key_reg, best_key_next;
    logic [TICK_W-1:0]  best_dlt_reg, best_dlt_next;
    logic               res_kind_reg, res_kind_next;
    logic [SLOT_W-1:0]  res_slot_reg, res_slot_next;
    logic [PER_W-1:0]   res_per_reg, res_per_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_kind_reg, out_kind_next;
    logic [SLOT_W-1:0]  out_slot_reg, out_slot_next;
    logic [PER_W-1:0]   out_per_reg, out_per_next;

    logic               in_acc;
    logic               out_free;
    logic               scan_done;
    logic               expired;

    // wakeup RAM
    logic               ram_we;
    logic [IDX_W-1:0]   ram_raddr;
    logic [TICK_W-1:0]  ram_wdata;
    logic [TICK_W-1:0]  ram_rdata;
    logic [TICK_W-1:0]  ev_dlt;
    logic [TICK_W-1:0]  ev_key;

    // divider
    logic               div_start;
    logic               div_done;
    logic [TICK_W-1:0]  div_quo;
    logic [TICK_W-1:0]  div_num;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign scan_done = (scan_reg == SCAN_W'(SLOTS));

    assign ram_we    = in_acc && slot_ok
                       && (in_cmd == CMD_ARM || in_cmd == CMD_ARM_LAST);
    assign ram_wdata = (in_cmd == CMD_ARM) ? in_wake : last_tick_reg;
    assign ram_raddr = scan_reg[IDX_W-1:0];

    // signed wrapped distance; flipping the sign bit makes an unsigned order
    assign ev_dlt = ram_rdata - now_reg;
    assign ev_key = {~ev_dlt[TICK_W-1], ev_dlt[TICK_W-2:0]};

    // expired when distance is negative or at most half a period
    assign expired = best_dlt_reg[TICK_W-1]
                     || (best_dlt_reg <= {{(TICK_W-GRAN_W){1'b0}}, half});

    assign div_num   = best_dlt_reg + {{(TICK_W-GRAN_W){1'b0}}, half};
    assign div_start = (state_reg == ST_DECIDE) && found_reg && !expired;

    tq_ram #(.WIDTH(TICK_W), .DEPTH(SLOTS)) u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_idx),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tq_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (gran),
        .done  (div_done),
        .quo   (div_quo)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in_cmd == CMD_DISPATCH)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = div_start ? ST_DIV : ST_EMIT;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (res_kind_reg == KIND_SLEEP) ? ST_IDLE : ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        armed_next     = armed_reg;
        last_tick_next = last_tick_reg;
        now_next       = now_reg;
        scan_next      = scan_reg;
        ev_vld_next    = 1'b0;
        ev_idx_next    = ev_idx_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_key_next  = best_key_reg;
        best_dlt_next  = best_dlt_reg;
        res_kind_next  = res_kind_reg;
        res_slot_next  = res_slot_reg;
        res_per_next   = res_per_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_slot_next  = out_slot_reg;
        out_per_next   = out_per_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_cmd == CMD_DISPATCH)
                    begin
                        now_next       = in_now;
                        last_tick_next = in_now;
                        scan_next      = '0;
                        found_next     = 1'b0;
                    end
                    else if (slot_ok)
                    begin
                        armed_next[slot_idx] = (in_cmd != CMD_CANCEL);
                    end
                end
            end
            ST_SCAN:
            begin
                if (!scan_done)
                begin
                    ev_vld_next = 1'b1;
                    ev_idx_next = ram_raddr;
                    scan_next   = scan_reg + 1'b1;
                end
                // strict compare keeps the lowest slot on a tie
                if (ev_vld_reg && armed_reg[ev_idx_reg]
                    && (!found_reg || ev_key < best_key_reg))
                begin
                    found_next    = 1'b1;
                    best_idx_next = ev_idx_reg;
                    best_key_next = ev_key;
                    best_dlt_next = ev_dlt;
                end
            end
            ST_DECIDE:
            begin
                res_slot_next = '0;
                res_per_next  = '0;
                if (!found_reg)
                begin
                    res_kind_next = KIND_SLEEP;
                    res_per_next  = PER_NONE;
                end
                else if (expired)
                begin
                    res_kind_next            = KIND_FIRED;
                    res_slot_next            = SLOT_W'(best_idx_reg);
                    armed_next[best_idx_reg] = 1'b0;
                end
                else
                begin
                    res_kind_next = KIND_SLEEP;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_per_next = div_quo[TICK_W-1] ? PER_MAX : div_quo;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = res_kind_reg;
                    out_slot_next  = res_slot_reg;
                    out_per_next   = res_per_reg;
                    scan_next      = '0;
                    found_next     = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            armed_reg     <= '0;
            last_tick_reg <= '0;
            scan_reg      <= '0;
            ev_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            armed_reg     <= armed_next;
            last_tick_reg <= last_tick_next;
            scan_reg      <= scan_next;
            ev_vld_reg    <= ev_vld_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        ev_idx_reg   <= ev_idx_next;
        best_idx_reg <= best_idx_next;
        best_key_reg <= best_key_next;
        best_dlt_reg <= best_dlt_next;
        res_kind_reg <= res_kind_next;
        res_slot_reg <= res_slot_next;
        res_per_reg  <= res_per_next;
        out_kind_reg <= out_kind_next;
        out_slot_reg <= out_slot_next;
        out_per_reg  <= out_per_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_per_reg, out_slot_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = (out_kind_reg == KIND_SLEEP);

endmodule

/* rtl/tq_ram.sv */
module tq_ram
    #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
    )
    (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/tq_div.sv */
// restoring divider, one quotient bit per cycle
module tq_div
    import tq_pkg::*;
    (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TICK_W-1:0] num,
    input  logic [GRAN_W-1:0] den,
    output logic              done,
    output logic [TICK_W-1:0] quo
    );

    localparam int CNT_W = $clog2(TICK_W);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TICK_W-1:0] num_reg, num_next;
    logic [TICK_W-1:0] quo_reg, quo_next;
    logic [GRAN_W:0]   rem_reg, rem_next;
    logic              done_reg, done_next;
    logic [GRAN_W:0]   rem_sh;
    logic [GRAN_W:0]   den_ext;

    assign den_ext = {1'b0, den};
    assign rem_sh  = {rem_reg[GRAN_W-1:0], num_reg[TICK_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = num;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[TICK_W-2:0], 1'b0};
            if (rem_sh >= den_ext)
            begin
                rem_next = rem_sh - den_ext;
                quo_next = {quo_reg[TICK_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[TICK_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(TICK_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

/* rtl/tq_chk.sv */
module tq_chk
    import tq_pkg::*;
    (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [IN_W-1:0]    s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [OUT_W-1:0]   m_tdata,
    input  logic               m_tuser,
    input  logic               m_tlast
    );

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item changed while stalled");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == m_tlast))
        else $error("sleep report and last disagree");

    a_fired: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[36:5] == 32'd0)
        else $error("slot report carries periods");

    a_sleep: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[4:0] == 5'd0
            && (!m_tdata[36] || m_tdata[36:5] == 32'hFFFF_FFFF))
        else $error("bad sleep report");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tdata[1:0] == CMD_DISPATCH |=> !s_tready)
        else $error("input taken during dispatch");

endmodule

bind timed_event_queue tq_chk u_chk (.*);

/* tb/tq_checker.sv */
`timescale 1ns / 100ps

// Watches the command and result streams, tracks the slot table and compares
// each dispatch report against its own prediction.
module tq_checker
    import tq_pkg::*;
    (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [IN_W-1:0]    s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [OUT_W-1:0]   m_tdata,
    input  logic               m_tuser,
    input  logic               m_tlast,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output int                 fail_count,
    output int                 pending_reports
    );

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot;
        logic [PER_W-1:0]  periods;
        logic              last;
    } report_t;

    report_t          report_q[$];
    logic             armed[32];
    logic [TICK_W-1:0] wakeup[32];
    logic [TICK_W-1:0] last_now;
    logic [GRAN_W-1:0] gran_reg;

    assign pending_reports = report_q.size();

    task automatic predict_dispatch(input logic [TICK_W-1:0] now);
        logic [63:0]       gran;
        logic [63:0]       half;
        logic [TICK_W-1:0] d;
        logic [TICK_W-1:0] bd;
        logic [TICK_W-1:0] bkey;
        logic [63:0]       per;
        int                best;
        report_t           r;
        last_now = now;
        gran = (gran_reg == 0) ? 64'd1 : 64'(gran_reg);
        half = gran >> 1;
        forever
        begin
            best = -1;
            bkey = '0;
            bd = '0;
            for (int i = 0; i < 32; i++)
            begin
                d = wakeup[i] - now;
                if (armed[i] && (best < 0 || (d ^ 32'h8000_0000) < bkey))
                begin
                    best = i;
                    bkey = d ^ 32'h8000_0000;
                    bd = d;
                end
            end
            if (best < 0)
            begin
                r = '{KIND_SLEEP, '0, PER_NONE, 1'b1};
                report_q.push_back(r);
                return;
            end
            if (!bd[TICK_W-1] && 64'(bd) > half)
            begin
                per = (64'(bd) + half) / gran;
                if (per > 64'(PER_MAX))
                    per = 64'(PER_MAX);
                r = '{KIND_SLEEP, '0, per[PER_W-1:0], 1'b1};
                report_q.push_back(r);
                return;
            end
            armed[best] = 1'b0;
            r = '{KIND_FIRED, SLOT_W'(best), '0, 1'b0};
            report_q.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cmd_t              cmd;
        logic [SLOT_W-1:0] sl;
        report_t           exp_r;
        if (!rst_n)
        begin
            report_q.delete();
            for (int i = 0; i < 32; i++)
            begin
                armed[i] = 1'b0;
                wakeup[i] = '0;
            end
            last_now = '0;
            gran_reg = GRAN_W'(1);
            fail_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_GRAN)
                gran_reg = pwdata[GRAN_W-1:0];
            if (s_tvalid && s_tready)
            begin
                cmd = cmd_t'(s_tdata[CMD_W-1:0]);
                sl = s_tdata[CMD_W +: SLOT_W];
                case (cmd)
                    CMD_ARM:
                    begin
                        armed[sl] = 1'b1;
                        wakeup[sl] = s_tdata[CMD_W+SLOT_W +: TICK_W];
                    end
                    CMD_ARM_LAST:
                    begin
                        armed[sl] = 1'b1;
                        wakeup[sl] = last_now;
                    end
                    CMD_CANCEL: armed[sl] = 1'b0;
                    default: predict_dispatch(s_tdata[CMD_W+SLOT_W+TICK_W +: TICK_W]);
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (report_q.size() == 0)
                begin
                    $error("unexpected report: kind %0d slot %0d", m_tuser,
                           m_tdata[SLOT_W-1:0]);
                    fail_count++;
                end
                else
                begin
                    exp_r = report_q.pop_front();
                    if (m_tuser !== exp_r.kind)
                    begin
                        $error("kind: expected %0d, actual %0d", exp_r.kind, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[SLOT_W-1:0] !== exp_r.slot)
                    begin
                        $error("fired_slot: expected %0d, actual %0d", exp_r.slot,
                               m_tdata[SLOT_W-1:0]);
                        fail_count++;
                    end
                    if (m_tdata[SLOT_W +: PER_W] !== exp_r.periods)
                    begin
                        $error("sleep_periods: expected %0d, actual %0d",
                               $signed(exp_r.periods), $signed(m_tdata[SLOT_W +: PER_W]));
                        fail_count++;
                    end
                    if (m_tlast !== exp_r.last)
                    begin
                        $error("last: expected %0d, actual %0d", exp_r.last, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

/* tb/timed_event_queue_tb.sv */
`timescale 1ns / 100ps

// Stimulus and verdict. Checking lives in tq_checker.
module timed_event_queue_tb;
    import tq_pkg::*;

    localparam int LIMIT = 1500000;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;   // command, slot, wakeup_tick, now_tick
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;   // fired_slot, sleep_periods
    logic               m_tuser;   // kind
    logic               m_tlast;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 fail_count;
    int                 pending_reports;
    int                 cycles;
    int                 send_idle_pct;   // chance in percent of a gap before an item
    int                 recv_stall_pct;  // chance in percent of m_tready low
    logic [TICK_W-1:0]  base_tick;       // moving "now" so armed ticks land nearby

    timed_event_queue DUT (.*);

    tq_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: count cycles, give up after a generous limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver stalls at random per the current phase.
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Valid stays high after the handshake; the next item or a gap replaces it.
    task automatic send_item(input cmd_t cmd, input int sl, input logic [31:0] wake,
                             input logic [31:0] now);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {now, wake, 5'(sl), cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Register writes only once the queue has drained; the first edge lets the
    // checker count a dispatch that was just handed over.
    task automatic write_gran(input logic [PADDR_W-1:0] addr, input logic [31:0] val);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_reports != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Random item: mostly arms around base_tick; also random arms, cancels and dispatches.
    task automatic random_item(input int span);
        int          r;
        logic [31:0] off;
        r = $urandom_range(99);
        off = $urandom_range(span);
        if ($urandom_range(1))
            off = -off;
        if (r < 45)
            send_item(CMD_ARM, $urandom_range(31), base_tick + off, $urandom);
        else if (r < 52)
            send_item(CMD_ARM, $urandom_range(31), $urandom, $urandom);
        else if (r < 60)
            send_item(CMD_ARM_LAST, $urandom_range(31), $urandom, $urandom);
        else if (r < 72)
            send_item(CMD_CANCEL, $urandom_range(31), $urandom, $urandom);
        else
        begin
            base_tick = base_tick + $urandom_range(span);
            if ($urandom_range(9) == 0)
                base_tick = $urandom;
            send_item(CMD_DISPATCH, $urandom_range(31), $urandom, base_tick);
        end
    endtask

    initial
    begin
        int span;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        base_tick = 32'h1000;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty dispatch, extremes of ticks and slots, ties,
        // re-arm, cancel of idle slot, arm at last dispatch, saturation.
        send_item(CMD_DISPATCH, 0, 32'h0, 32'h0);
        send_item(CMD_ARM, 31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_ARM, 0, 32'h0, 32'h0);
        send_item(CMD_ARM, 5, 32'h0, 32'h0);
        send_item(CMD_ARM, 5, 32'h7FFF_FFFF, 32'h0);
        send_item(CMD_CANCEL, 9, 32'h0, 32'h0);
        send_item(CMD_DISPATCH, 31, 32'hFFFF_FFFF, 32'h0);
        send_item(CMD_DISPATCH, 0, 32'h0, 32'h8000_0000);
        send_item(CMD_ARM_LAST, 3, 32'h0, 32'h0);
        send_item(CMD_ARM_LAST, 4, 32'h0, 32'h0);
        send_item(CMD_CANCEL, 4, 32'h0, 32'h0);
        send_item(CMD_DISPATCH, 0, 32'h0, 32'h8000_0000);
        write_gran(ADDR_GRAN, 32'hFFFF_FFFF);
        send_item(CMD_ARM, 1, 32'h4000_0000, 32'h0);
        send_item(CMD_ARM, 2, 32'h7FFF_FFFF, 32'h0);
        send_item(CMD_DISPATCH, 0, 32'h0, 32'h0);
        send_item(CMD_DISPATCH, 0, 32'h0, 32'h0);
        write_gran(ADDR_GRAN, 32'h0);
        send_item(CMD_ARM, 7, 32'h10, 32'h0);
        send_item(CMD_DISPATCH, 0, 32'h0, 32'h10);
        write_gran(3'd4, 32'h5);  // unmapped address, ignored
        send_item(CMD_DISPATCH, 0, 32'h0, 32'h0);

        // Random phases: no idling, sender gaps, receiver stalls, both.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            case (ph)
                0: write_gran(ADDR_GRAN, 32'd1);
                1: write_gran(ADDR_GRAN, 32'd2);
                2: write_gran(ADDR_GRAN, 32'd100);
                3: write_gran(ADDR_GRAN, 32'd7);
                4: write_gran(ADDR_GRAN, 32'h7FFF_FFFF);
                5: write_gran(ADDR_GRAN, $urandom);
                6: write_gran(ADDR_GRAN, 32'd1000);
                default: write_gran(ADDR_GRAN, 32'd0);
            endcase
            span = (ph == 4 || ph == 5) ? 32'h7FFF_FFFF : 2000;
            for (int n = 0; n < 58; n++)
                random_item(span);
        end

        send_idle_pct = 0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_reports != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/tq_pkg.sv
rtl/tq_ram.sv
rtl/tq_div.sv
rtl/timed_event_queue.sv
rtl/tq_chk.sv
tb/tq_checker.sv
tb/timed_event_queue_tb.sv
